FILE: rtl/dmas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmas_pkg
// Shared types and widths of the beam combiner: the per-voxel summary record
// that the accumulation front end hands to the normalization back end.
// ----------------------------------------------------------------------------
package dmas_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 17;
    localparam int PREFIX_W = 23;
    localparam int PAIR_W   = 44;
    localparam int ENERGY_W = 38;
    localparam int OUT_W    = 48;
    localparam int COUNT_W  = 7;
    localparam int CF_W     = 17;

    localparam logic [1:0] CFG_COMBINE_MODE = 2'd0;
    localparam logic [1:0] CFG_COHERENCE    = 2'd1;
    localparam logic [1:0] CFG_STREAM_COUNT = 2'd2;

    typedef struct packed {
        logic                       mode;
        logic                       coh;
        logic [COUNT_W-1:0]         n;
        logic signed [PREFIX_W-1:0] ps_re;
        logic signed [PREFIX_W-1:0] ps_im;
        logic signed [PAIR_W-1:0]   pair_re;
        logic signed [PAIR_W-1:0]   pair_im;
        logic [ENERGY_W-1:0]        energy;
    } voxel_t;

endpackage

FILE: rtl/dmas_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmas_queue
// Two-entry queue of voxel summaries between front end and back end.
// ----------------------------------------------------------------------------
module dmas_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  dmas_pkg::voxel_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output dmas_pkg::voxel_t pop_data
);

    dmas_pkg::voxel_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/dmas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmas_front
// Interpolates, rotates and accumulates one stream item at a time; at the end
// of a voxel pushes the accumulator summary into the queue and clears.
// ----------------------------------------------------------------------------
module dmas_front #(
    parameter int MAX_STREAMS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [6:0]         cfg_count,
    input  logic               cfg_mode,
    input  logic               cfg_coh,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_early_re,
    input  logic signed [15:0] s_early_im,
    input  logic signed [15:0] s_late_re,
    input  logic signed [15:0] s_late_im,
    input  logic [16:0]        s_early_weight,
    input  logic [16:0]        s_late_weight,
    input  logic signed [15:0] s_phasor_re,
    input  logic signed [15:0] s_phasor_im,
    output logic               q_push,
    output dmas_pkg::voxel_t   q_data,
    input  logic               q_full
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INT_RE = 4'd1;
    localparam logic [3:0] ST_INT_IM = 4'd2;
    localparam logic [3:0] ST_ROT_RE = 4'd3;
    localparam logic [3:0] ST_ROT_IM = 4'd4;
    localparam logic [3:0] ST_PAIR_A = 4'd5;
    localparam logic [3:0] ST_PAIR_B = 4'd6;
    localparam logic [3:0] ST_ENERGY = 4'd7;
    localparam logic [3:0] ST_ACC    = 4'd8;

    function automatic logic signed [15:0] sat16(input logic signed [34:0] x);
        if (x > 35'sd32767) begin
            sat16 = 16'sh7FFF;
        end else if (x < -35'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = x[15:0];
        end
    endfunction

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic signed [15:0] er_reg, ei_reg, lr_reg, li_reg, pr_reg, pi_reg;
    logic signed [17:0] ew_reg, lw_reg;
    logic signed [15:0] yr_reg, yi_reg, ar_reg, ai_reg;
    logic signed [38:0] p_a_reg, p_b_reg;
    logic signed [38:0] p_c_reg, p_d_reg;
    logic [31:0]        esq_reg;

    logic signed [22:0] ps_re_reg, ps_im_reg;
    logic signed [43:0] pair_re_reg, pair_im_reg;
    logic [37:0]        energy_reg;
    logic [6:0]         idx_reg;

    logic signed [34:0] int_re_sum, int_im_sum, rot_re_sum, rot_im_sum;
    logic signed [32:0] esq_w;
    logic signed [45:0] pair_re_sum, pair_im_sum;
    logic signed [43:0] pair_re_next, pair_im_next;
    logic signed [23:0] ps_re_sum, ps_im_sum;
    logic signed [22:0] ps_re_next, ps_im_next;
    logic [38:0]        energy_sum;
    logic [37:0]        energy_next;
    logic [6:0]         idx_inc;
    logic [6:0]         n_w;
    logic               voxel_done;

    assign s_ready = (state_reg == ST_IDLE);

    assign int_re_sum = er_reg * ew_reg + lr_reg * lw_reg + 35'sd32768;
    assign int_im_sum = ei_reg * ew_reg + li_reg * lw_reg + 35'sd32768;
    assign rot_re_sum = yr_reg * pr_reg - yi_reg * pi_reg + 35'sd16384;
    assign rot_im_sum = yr_reg * pi_reg + yi_reg * pr_reg + 35'sd16384;
    assign esq_w      = ar_reg * ar_reg + ai_reg * ai_reg;

    always_comb begin
        if (cfg_count == 7'd0) begin
            n_w = 7'd1;
        end else if (MAX_STREAMS < 127 && cfg_count > MAX_STREAMS) begin
            n_w = 7'(MAX_STREAMS);
        end else begin
            n_w = cfg_count;
        end

        pair_re_sum = pair_re_reg + p_a_reg + p_b_reg;
        pair_im_sum = pair_im_reg + p_c_reg - p_d_reg;
        if (pair_re_sum > 46'sh007FFFFFFFFFF) begin
            pair_re_next = 44'sh7FFFFFFFFFF;
        end else if (pair_re_sum < -46'sh00080000000000) begin
            pair_re_next = 44'sh80000000000;
        end else begin
            pair_re_next = pair_re_sum[43:0];
        end
        if (pair_im_sum > 46'sh007FFFFFFFFFF) begin
            pair_im_next = 44'sh7FFFFFFFFFF;
        end else if (pair_im_sum < -46'sh00080000000000) begin
            pair_im_next = 44'sh80000000000;
        end else begin
            pair_im_next = pair_im_sum[43:0];
        end

        ps_re_sum = ps_re_reg + ar_reg;
        ps_im_sum = ps_im_reg + ai_reg;
        if (ps_re_sum > 24'sd4194303) begin
            ps_re_next = 23'sh3FFFFF;
        end else if (ps_re_sum < -24'sd4194304) begin
            ps_re_next = 23'sh400000;
        end else begin
            ps_re_next = ps_re_sum[22:0];
        end
        if (ps_im_sum > 24'sd4194303) begin
            ps_im_next = 23'sh3FFFFF;
        end else if (ps_im_sum < -24'sd4194304) begin
            ps_im_next = 23'sh400000;
        end else begin
            ps_im_next = ps_im_sum[22:0];
        end

        energy_sum  = {1'b0, energy_reg} + {7'd0, esq_reg};
        energy_next = energy_sum[38] ? {38{1'b1}} : energy_sum[37:0];

        idx_inc    = idx_reg + 7'd1;
        voxel_done = (idx_inc >= n_w);
    end

    always_comb begin
        q_data.mode    = cfg_mode;
        q_data.coh     = cfg_coh;
        q_data.n       = n_w;
        q_data.ps_re   = ps_re_next;
        q_data.ps_im   = ps_im_next;
        q_data.pair_re = pair_re_next;
        q_data.pair_im = pair_im_next;
        q_data.energy  = energy_next;
        q_push         = (state_reg == ST_ACC) && voxel_done && !q_full;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_INT_RE;
                end
            end
            ST_INT_RE: state_next = ST_INT_IM;
            ST_INT_IM: state_next = ST_ROT_RE;
            ST_ROT_RE: state_next = ST_ROT_IM;
            ST_ROT_IM: state_next = ST_PAIR_A;
            ST_PAIR_A: state_next = ST_PAIR_B;
            ST_PAIR_B: state_next = ST_ENERGY;
            ST_ENERGY: state_next = ST_ACC;
            ST_ACC: begin
                if (!voxel_done || !q_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                er_reg <= s_early_re;
                ei_reg <= s_early_im;
                lr_reg <= s_late_re;
                li_reg <= s_late_im;
                ew_reg <= {1'b0, s_early_weight};
                lw_reg <= {1'b0, s_late_weight};
                pr_reg <= s_phasor_re;
                pi_reg <= s_phasor_im;
            end
            ST_INT_RE: yr_reg <= sat16(int_re_sum >>> 16);
            ST_INT_IM: yi_reg <= sat16(int_im_sum >>> 16);
            ST_ROT_RE: ar_reg <= sat16(rot_re_sum >>> 15);
            ST_ROT_IM: ai_reg <= sat16(rot_im_sum >>> 15);
            ST_PAIR_A: begin
                p_a_reg <= ps_re_reg * ar_reg;
                p_b_reg <= ps_im_reg * ai_reg;
            end
            ST_PAIR_B: begin
                p_c_reg <= ps_im_reg * ar_reg;
                p_d_reg <= ps_re_reg * ai_reg;
            end
            ST_ENERGY: esq_reg <= esq_w[31:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ps_re_reg   <= '0;
            ps_im_reg   <= '0;
            pair_re_reg <= '0;
            pair_im_reg <= '0;
            energy_reg  <= '0;
            idx_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ACC) begin
                if (!voxel_done) begin
                    ps_re_reg   <= ps_re_next;
                    ps_im_reg   <= ps_im_next;
                    pair_re_reg <= pair_re_next;
                    pair_im_reg <= pair_im_next;
                    energy_reg  <= energy_next;
                    idx_reg     <= idx_inc;
                end else if (!q_full) begin
                    ps_re_reg   <= '0;
                    ps_im_reg   <= '0;
                    pair_re_reg <= '0;
                    pair_im_reg <= '0;
                    energy_reg  <= '0;
                    idx_reg     <= '0;
                end
            end
        end
    end

endmodule

FILE: rtl/dmas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmas_back
// Normalizes one voxel summary: divides by the stream count, works out the
// coherence factor by long division, scales if enabled, drives the result register.
// ----------------------------------------------------------------------------
module dmas_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  dmas_pkg::voxel_t   q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_pixel_re,
    output logic signed [47:0] m_pixel_im,
    output logic               m_zero_energy
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_PREP  = 3'd1;
    localparam logic [2:0] B_DEN   = 3'd2;
    localparam logic [2:0] B_RATIO = 3'd3;
    localparam logic [2:0] B_DIV   = 3'd4;
    localparam logic [2:0] B_SCALE = 3'd5;
    localparam logic [2:0] B_OUT   = 3'd6;

    localparam logic [5:0] DIV_LAST = 6'(dmas_pkg::PAIR_W - 1);
    localparam logic [5:0] CF_STEPS = 6'(dmas_pkg::CF_W);

    logic [2:0] state_reg;

    dmas_pkg::voxel_t   snap_reg;
    logic               neg_re_reg, neg_im_reg;
    logic [43:0]        mag_re_reg, mag_im_reg;
    logic [6:0]         rem_re_reg, rem_im_reg;
    logic [45:0]        sq_re_reg, sq_im_reg;
    logic [44:0]        den_reg;
    logic [62:0]        num_reg;
    logic [62:0]        dsh_reg;
    logic               cap_reg;
    logic [16:0]        cfq_reg;
    logic [5:0]         cnt_reg;
    logic [60:0]        prod_re_reg, prod_im_reg;

    logic               m_valid_reg;
    logic signed [47:0] m_pixel_re_reg, m_pixel_im_reg;
    logic               m_zero_energy_reg;

    logic signed [43:0] v_re, v_im;
    logic [7:0]         rsh_re, rsh_im;
    logic               qb_re, qb_im;
    logic               cf_ge;
    logic [16:0]        cf_w;
    logic [43:0]        res_re, res_im;
    logic [47:0]        ext_re, ext_im;
    logic               out_free;
    logic               zero_e;

    assign m_valid       = m_valid_reg;
    assign m_pixel_re    = m_pixel_re_reg;
    assign m_pixel_im    = m_pixel_im_reg;
    assign m_zero_energy = m_zero_energy_reg;

    assign q_pop    = (state_reg == B_IDLE) && q_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign zero_e   = (snap_reg.energy == '0);

    always_comb begin
        if (snap_reg.mode) begin
            v_re = snap_reg.pair_re;
            v_im = snap_reg.pair_im;
        end else begin
            v_re = {{6{snap_reg.ps_re[22]}}, snap_reg.ps_re, 15'd0};
            v_im = {{6{snap_reg.ps_im[22]}}, snap_reg.ps_im, 15'd0};
        end

        rsh_re = {rem_re_reg, mag_re_reg[43]};
        rsh_im = {rem_im_reg, mag_im_reg[43]};
        qb_re  = (rsh_re >= {1'b0, snap_reg.n});
        qb_im  = (rsh_im >= {1'b0, snap_reg.n});
        cf_ge  = (num_reg >= dsh_reg);

        if (cap_reg || cfq_reg > 17'd65536) begin
            cf_w = 17'd65536;
        end else begin
            cf_w = cfq_reg;
        end

        if (!snap_reg.coh) begin
            res_re = mag_re_reg;
            res_im = mag_im_reg;
        end else begin
            res_re = prod_re_reg[59:16];
            res_im = prod_im_reg[59:16];
        end
        ext_re = neg_re_reg ? -{4'd0, res_re} : {4'd0, res_re};
        ext_im = neg_im_reg ? -{4'd0, res_im} : {4'd0, res_im};
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                snap_reg <= q_data;
            end
            B_PREP: begin
                neg_re_reg <= v_re[43];
                neg_im_reg <= v_im[43];
                mag_re_reg <= v_re[43] ? 44'(-v_re) : v_re;
                mag_im_reg <= v_im[43] ? 44'(-v_im) : v_im;
                rem_re_reg <= '0;
                rem_im_reg <= '0;
                sq_re_reg  <= 46'(snap_reg.ps_re * snap_reg.ps_re);
                sq_im_reg  <= 46'(snap_reg.ps_im * snap_reg.ps_im);
            end
            B_DEN: begin
                den_reg <= snap_reg.n * snap_reg.energy;
                num_reg <= {sq_re_reg + sq_im_reg, 16'd0};
            end
            B_RATIO: begin
                cap_reg <= (num_reg >= {1'b0, den_reg, 17'd0});
                dsh_reg <= {2'd0, den_reg, 16'd0};
                cfq_reg <= '0;
            end
            B_DIV: begin
                mag_re_reg <= {mag_re_reg[42:0], qb_re};
                mag_im_reg <= {mag_im_reg[42:0], qb_im};
                rem_re_reg <= qb_re ? 7'(rsh_re - {1'b0, snap_reg.n}) : rsh_re[6:0];
                rem_im_reg <= qb_im ? 7'(rsh_im - {1'b0, snap_reg.n}) : rsh_im[6:0];
                if (cnt_reg < CF_STEPS) begin
                    if (cf_ge) begin
                        num_reg <= num_reg - dsh_reg;
                    end
                    cfq_reg <= {cfq_reg[15:0], cf_ge};
                    dsh_reg <= dsh_reg >> 1;
                end
            end
            B_SCALE: begin
                prod_re_reg <= mag_re_reg * cf_w;
                prod_im_reg <= mag_im_reg * cf_w;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != B_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        state_reg <= B_PREP;
                    end
                end
                B_PREP:  state_reg <= B_DEN;
                B_DEN:   state_reg <= B_RATIO;
                B_RATIO: begin
                    cnt_reg   <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= B_SCALE;
                    end
                end
                B_SCALE: state_reg <= B_OUT;
                B_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_OUT && out_free) begin
            if (snap_reg.coh && zero_e) begin
                m_pixel_re_reg    <= '0;
                m_pixel_im_reg    <= '0;
                m_zero_energy_reg <= 1'b1;
            end else begin
                m_pixel_re_reg    <= ext_re;
                m_pixel_im_reg    <= ext_im;
                m_zero_energy_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/das_dmas_beam_combiner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// das_dmas_beam_combiner_unit
// Delay-and-sum / delay-multiply-and-sum voxel combiner with optional
// coherence factor weighting.
//
//   channel   prefix   direction   contents
//   input     s_       in          one stream item: samples, weights, phasor
//   result    m_       out         one voxel value and zero-energy flag
//   config    cfg_     in          register writes, no read-back
//
// the front end takes one stream item at a time: accept, then an 8-step
// multiply sequencer that holds its last step while the queue is full; the
// back end normalizes a voxel with a 44-step bit-serial divide by the stream count
// a two-entry queue between them lets the front keep accumulating while a
// voxel is normalized or its result waits on m_ready
// synchronous active-low reset clears accumulators and queue and resets config
// ----------------------------------------------------------------------------
module das_dmas_beam_combiner_unit #(
    parameter int MAX_STREAMS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_early_re,
    input  logic signed [15:0] s_early_im,
    input  logic signed [15:0] s_late_re,
    input  logic signed [15:0] s_late_im,
    input  logic [16:0]        s_early_weight,
    input  logic [16:0]        s_late_weight,
    input  logic signed [15:0] s_phasor_re,
    input  logic signed [15:0] s_phasor_im,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_pixel_re,
    output logic signed [47:0] m_pixel_im,
    output logic               m_zero_energy
);

    logic       mode_reg;
    logic       coh_reg;
    logic [6:0] count_reg;

    logic             q_push, q_full, q_pop, q_not_empty;
    dmas_pkg::voxel_t q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            coh_reg   <= 1'b0;
            count_reg <= 7'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                dmas_pkg::CFG_COMBINE_MODE: mode_reg  <= cfg_wdata[0];
                dmas_pkg::CFG_COHERENCE:    coh_reg   <= cfg_wdata[0];
                dmas_pkg::CFG_STREAM_COUNT: count_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    dmas_front #(
        .MAX_STREAMS(MAX_STREAMS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_count     (count_reg),
        .cfg_mode      (mode_reg),
        .cfg_coh       (coh_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_early_re    (s_early_re),
        .s_early_im    (s_early_im),
        .s_late_re     (s_late_re),
        .s_late_im     (s_late_im),
        .s_early_weight(s_early_weight),
        .s_late_weight (s_late_weight),
        .s_phasor_re   (s_phasor_re),
        .s_phasor_im   (s_phasor_im),
        .q_push        (q_push),
        .q_data        (q_in),
        .q_full        (q_full)
    );

    dmas_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_data (q_out)
    );

    dmas_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_not_empty),
        .q_pop        (q_pop),
        .q_data       (q_out),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_re   (m_pixel_re),
        .m_pixel_im   (m_pixel_im),
        .m_zero_energy(m_zero_energy)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DAS/DMAS beam combiner. A directed table of
// stream items (extremes, zero energy, count changes) is followed by random
// phases over several register settings. Every accepted item goes through
// an in-bench voxel predictor. Each voxel transfer is compared field by field
// with the oldest expected pixel. Both channels idle at random unless no_idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_CYCLES = 120;
    localparam int WDOG_LIMIT  = 20000;

    typedef struct {
        logic signed [15:0] er, ei, lr, li;
        logic [16:0]        ew, lw;
        logic signed [15:0] pr, pi;
    } stream_item_t;

    typedef struct {
        logic signed [47:0] re, im;
        logic               zf;
    } pixel_t;

    typedef struct {
        int     mode, coh, cnt;
        int     er, ei, lr, li, ew, lw, pr, pi;
        bit     chk;
        longint xre, xim;
        bit     xzf;
    } dir_row_t;

    typedef struct {
        int mode, coh, cnt, items;
        bit no_idle;
    } phase_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [6:0]         cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_early_re, s_early_im, s_late_re, s_late_im;
    logic [16:0]        s_early_weight, s_late_weight;
    logic signed [15:0] s_phasor_re, s_phasor_im;
    logic               m_valid;
    logic               m_ready;
    logic signed [47:0] m_pixel_re, m_pixel_im;
    logic               m_zero_energy;

    das_dmas_beam_combiner_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_early_re     (s_early_re),
        .s_early_im     (s_early_im),
        .s_late_re      (s_late_re),
        .s_late_im      (s_late_im),
        .s_early_weight (s_early_weight),
        .s_late_weight  (s_late_weight),
        .s_phasor_re    (s_phasor_re),
        .s_phasor_im    (s_phasor_im),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_re     (m_pixel_re),
        .m_pixel_im     (m_pixel_im),
        .m_zero_energy  (m_zero_energy)
    );

    // predictor state
    int     mdl_mode, mdl_coh;
    int     mdl_cnt;
    longint ps_re, ps_im, pair_re, pair_im, energy;
    int     strm_idx;

    pixel_t pixel_q[$];
    int     n_err;
    bit     no_idle;
    int     wdog;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint sat_w(longint x, int w);
        longint lim;
        lim = 64'sd1 <<< (w - 1);
        if (x > lim - 1) return lim - 1;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic longint rnd_sh(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint cf_scale(longint v, longint unsigned cf);
        longint unsigned mag;
        longint          q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q   = longint'((mag * cf) >> 16);
        return (v < 0) ? -q : q;
    endfunction

    // one stream contribution; emit is set when the voxel completes
    function automatic void accumulate_stream(input stream_item_t it, output bit emit,
                                              output pixel_t px);
        longint yr, yi, ar, ai, vr, vi, ew, lw, emax;
        longint unsigned s2, cf;
        int n;
        ew = longint'({47'd0, it.ew});
        lw = longint'({47'd0, it.lw});
        yr = sat_w(rnd_sh(longint'(it.er) * ew + longint'(it.lr) * lw, 16), 16);
        yi = sat_w(rnd_sh(longint'(it.ei) * ew + longint'(it.li) * lw, 16), 16);
        ar = sat_w(rnd_sh(yr * longint'(it.pr) - yi * longint'(it.pi), 15), 16);
        ai = sat_w(rnd_sh(yr * longint'(it.pi) + yi * longint'(it.pr), 15), 16);
        pair_re = sat_w(pair_re + ps_re * ar + ps_im * ai, dmas_pkg::PAIR_W);
        pair_im = sat_w(pair_im + ps_im * ar - ps_re * ai, dmas_pkg::PAIR_W);
        ps_re   = sat_w(ps_re + ar, dmas_pkg::PREFIX_W);
        ps_im   = sat_w(ps_im + ai, dmas_pkg::PREFIX_W);
        emax    = (64'sd1 <<< dmas_pkg::ENERGY_W) - 1;
        energy  = energy + ar * ar + ai * ai;
        if (energy > emax) energy = emax;
        n = mdl_cnt;
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        strm_idx++;
        emit = 1'b0;
        px   = '{re: '0, im: '0, zf: 1'b0};
        if (strm_idx < n) return;
        emit = 1'b1;
        if (mdl_mode != 0) begin
            vr = pair_re / n;
            vi = pair_im / n;
        end else begin
            vr = (ps_re * 32768) / n;
            vi = (ps_im * 32768) / n;
        end
        if (mdl_coh != 0) begin
            if (energy == 0) begin
                vr = 0;
                vi = 0;
                px.zf = 1'b1;
            end else begin
                s2 = longint'(ps_re * ps_re + ps_im * ps_im);
                cf = (s2 << 16) / (longint'(n) * energy);
                if (cf > 65536) cf = 65536;
                vr = cf_scale(vr, cf);
                vi = cf_scale(vi, cf);
            end
        end
        px.re = 48'(sat_w(vr, dmas_pkg::OUT_W));
        px.im = 48'(sat_w(vi, dmas_pkg::OUT_W));
        ps_re = 0; ps_im = 0; pair_re = 0; pair_im = 0; energy = 0; strm_idx = 0;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic stream_item_t rand_item();
        stream_item_t it;
        it.er = rand_sample();
        it.ei = rand_sample();
        it.lr = rand_sample();
        it.li = rand_sample();
        case ($urandom_range(0, 7))
            0: begin
                it.ew = 17'($urandom());
                it.lw = 17'($urandom());
            end
            1: begin
                it.ew = 17'h10000;
                it.lw = 17'h0;
            end
            default: begin
                it.ew = 17'($urandom_range(0, 65536));
                it.lw = 17'h10000 - it.ew;
            end
        endcase
        it.pr = rand_sample();
        it.pi = rand_sample();
        return it;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // one input transfer; returns at the edge that accepts it
    task automatic send_stream(input stream_item_t it, input bit typed, input pixel_t tpx);
        int     gap;
        bit     emit;
        pixel_t px;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_early_re     <= it.er;
        s_early_im     <= it.ei;
        s_late_re      <= it.lr;
        s_late_im      <= it.li;
        s_early_weight <= it.ew;
        s_late_weight  <= it.lw;
        s_phasor_re    <= it.pr;
        s_phasor_im    <= it.pi;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        accumulate_stream(it, emit, px);
        if (emit) pixel_q.push_back(typed ? tpx : px);
    endtask

    task automatic drain_and_wait();
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input int mode, input int coh, input int cnt);
        cfg_we    <= 1'b1;
        cfg_index <= dmas_pkg::CFG_COMBINE_MODE;
        cfg_wdata <= 7'(mode);
        @(posedge aclk);
        cfg_index <= dmas_pkg::CFG_COHERENCE;
        cfg_wdata <= 7'(coh);
        @(posedge aclk);
        cfg_index <= dmas_pkg::CFG_STREAM_COUNT;
        cfg_wdata <= 7'(cnt);
        @(posedge aclk);
        cfg_we <= 1'b0;
        mdl_mode = mode & 1;
        mdl_coh  = coh & 1;
        mdl_cnt  = cnt & 7'h7f;
    endtask

    dir_row_t dir_tab[18] = '{
        '{0, 0, 1,      0,     0,     0,     0,      0,      0,      0,      0,
          1, 0, 0, 0},
        '{0, 0, 1,  16384,     0,     0,     0,  65536,      0, -32768,      0,
          1, -536870912, 0, 0},
        '{0, 0, 1, -32768, 32767, -32768, 32767,  65536,  65536,  32767, -32768,
          0, 0, 0, 0},
        '{0, 0, 1,  32767, -32768, 32767, -32768, 131071, 131071, -32768, -32768,
          0, 0, 0, 0},
        '{1, 0, 1,  12345,  -777,  -222,  3000,  30000,  35536,  20000,   9000,
          1, 0, 0, 0},
        '{1, 0, 3,  32767, 32767, 32767, 32767,  65536,      0,  32767,  32767,
          0, 0, 0, 0},
        '{1, 0, 3, -32768, -32768, -32768, -32768, 0,    65536,  32767, -32768,
          0, 0, 0, 0},
        '{1, 0, 3,   1000, -2000,  3000, -4000,  20000,  45536, -32768,  32767,
          0, 0, 0, 0},
        '{0, 0, 4,  -5000,  6000, -7000,  8000,  40000,  25536,  12000, -31000,
          0, 0, 0, 0},
        '{0, 0, 4,  32767, -32768,    0,    -1,  65536,  65536,      0,  32767,
          0, 0, 0, 0},
        '{0, 0, 2,    100,   200,   300,   400,  32768,  32768,  32767,      0,
          0, 0, 0, 0},
        '{0, 1, 1,      0,     0,     0,     0,      0,      0,      0,      0,
          1, 0, 0, 1},
        '{1, 1, 2,  32767, 32767, 32767, 32767,      0,      0,  32767,  32767,
          0, 0, 0, 0},
        '{1, 1, 2,      0,     0,     0,     0,  65536,  65536, -32768, -32768,
          1, 0, 0, 1},
        '{0, 1, 1,  16384,     0,     0,     0,  65536,      0, -32768,      0,
          1, -536870912, 0, 0},
        '{0, 0, 0,  -1234,  5678, -9012,  3456,  10000,  55536,  -2000,  30000,
          0, 0, 0, 0},
        '{1, 1, 127, 22222, -11111, 3333, -4444, 50000,  15536,  16000,  16000,
          0, 0, 0, 0},
        '{1, 1, 127, -22222, 11111, -3333, 4444, 50000,  15536,  16000,  16000,
          0, 0, 0, 0}
    };

    phase_t phases[9] = '{
        '{0, 0, 1,   200, 0},
        '{1, 0, 2,   200, 0},
        '{0, 1, 5,   200, 1},
        '{1, 1, 64,  260, 0},
        '{0, 0, 127, 130, 0},
        '{1, 1, 0,   150, 0},
        '{1, 0, 3,   200, 1},
        '{0, 1, 1,   150, 0},
        '{1, 1, 8,   260, 0}
    };

    // sender
    initial begin
        stream_item_t it;
        pixel_t       tpx;
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 1'b0;
        s_early_re = '0; s_early_im = '0; s_late_re = '0; s_late_im = '0;
        s_early_weight = '0; s_late_weight = '0; s_phasor_re = '0; s_phasor_im = '0;
        mdl_mode = 0; mdl_coh = 0; mdl_cnt = 1;
        ps_re = 0; ps_im = 0; pair_re = 0; pair_im = 0; energy = 0; strm_idx = 0;
        no_idle = 1'b0;
        n_err = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode != mdl_mode || dir_tab[i].coh != mdl_coh ||
                dir_tab[i].cnt != mdl_cnt) begin
                drain_and_wait();
                write_regs(dir_tab[i].mode, dir_tab[i].coh, dir_tab[i].cnt);
            end
            it.er = 16'(dir_tab[i].er); it.ei = 16'(dir_tab[i].ei);
            it.lr = 16'(dir_tab[i].lr); it.li = 16'(dir_tab[i].li);
            it.ew = 17'(dir_tab[i].ew); it.lw = 17'(dir_tab[i].lw);
            it.pr = 16'(dir_tab[i].pr); it.pi = 16'(dir_tab[i].pi);
            tpx.re = 48'(dir_tab[i].xre);
            tpx.im = 48'(dir_tab[i].xim);
            tpx.zf = dir_tab[i].xzf;
            send_stream(it, dir_tab[i].chk, tpx);
        end
        foreach (phases[p]) begin
            drain_and_wait();
            write_regs(phases[p].mode, phases[p].coh, phases[p].cnt);
            no_idle = phases[p].no_idle;
            repeat (phases[p].items) send_stream(rand_item(), 1'b0, tpx);
        end
        drain_and_wait();
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // result side
    initial begin
        int     stall;
        pixel_t x;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pixel_q.size() == 0) begin
                n_err++;
                $display("%0t unexpected voxel transfer re=%0d im=%0d zf=%0b",
                         $time, m_pixel_re, m_pixel_im, m_zero_energy);
            end else begin
                x = pixel_q.pop_front();
                if (m_pixel_re !== x.re) begin
                    n_err++;
                    $display("%0t pixel_re exp=%0d got=%0d", $time, x.re, m_pixel_re);
                end
                if (m_pixel_im !== x.im) begin
                    n_err++;
                    $display("%0t pixel_im exp=%0d got=%0d", $time, x.im, m_pixel_im);
                end
                if (m_zero_energy !== x.zf) begin
                    n_err++;
                    $display("%0t zero_energy exp=%0b got=%0b", $time, x.zf,
                             m_zero_energy);
                end
            end
        end
    end

    // watchdog
    initial wdog = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            wdog <= 0;
        end else if (wdog >= WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

endmodule

FILE: filelist.f
rtl/dmas_pkg.sv
rtl/dmas_queue.sv
rtl/dmas_front.sv
rtl/dmas_back.sv
rtl/das_dmas_beam_combiner_unit.sv
tb/sv/tb_top.sv
